FILE: design/aes_cbc_pkg.sv
// AES-CBC package: S-box table, round helper functions and shared constants.
// No dependencies; imported by aes_cbc_encrypt_top.
package aes_cbc_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_KEY_SIZE  = 3'd0;
   localparam logic [2:0] REG_KEY_WORD0 = 3'd1;
   localparam logic [2:0] REG_KEY_WORD1 = 3'd2;
   localparam logic [2:0] REG_KEY_WORD2 = 3'd3;
   localparam logic [2:0] REG_KEY_WORD3 = 3'd4;
   localparam logic [2:0] REG_IV_HIGH   = 3'd5;
   localparam logic [2:0] REG_IV_LOW    = 3'd6;

   localparam logic [63:0] IV_RESET = 64'h5252_5252_5252_5252;
   localparam logic [7:0]  RCON_FIRST = 8'h01;
   localparam logic [7:0]  GF_POLY = 8'h1b;

   typedef logic [127:0] block_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Multiply by x in GF(2^8).
   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // SubBytes and ShiftRows; byte k of the state sits at bits 127-8k.
   function automatic block_type sub_shift(input block_type s);
      block_type t;
      int c;
      int r;
      t = '0;
      for (c = 0; c < 4; c++) begin
         for (r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
         end
      end
      sub_shift = t;
   endfunction

   function automatic block_type mix_columns(input block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3;
      int c;
      t = '0;
      for (c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      mix_columns = t;
   endfunction

endpackage

FILE: design/aes_cbc_encrypt_top.sv
// AES-CBC encryption top level: key expansion sequencer, round-key memory and round loop.
// Depends on aes_cbc_pkg.
//
// Usage: blocks enter on the req_ channel (plaintext plus a restart flag that
// chains from the IV instead of the previous ciphertext) and leave on the rsp_
// channel, one ciphertext beat per block, in order. Key size, key and IV are
// written on the csr_ channel, which is always ready; write them only while
// no block is in flight.
// After reset, and after any write of key size or key, the round keys are
// expanded into the round-key memory one word per cycle: 44, 52 or 60 words
// for 128, 192 or 256 bit keys. No block is accepted during that time.
// Each block then runs one round per cycle from acceptance to a valid result,
// paced by the one round-key row read from memory per cycle. One block is
// processed at a time; the next block may be accepted in the cycle after the
// result lands in the output register. If the receiver stalls, the finished
// round waits until the output register is free. Reset clears the chain value
// to zero.
module aes_cbc_encrypt_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_plain_high,
   input  logic [63:0] req_plain_low,
   input  logic        req_restart_chain,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_cipher_high,
   output logic [63:0] rsp_cipher_low,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import aes_cbc_pkg::*;

   localparam logic [1:0] ST_EXPAND = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_RUN    = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  key_size_ff;
   logic [63:0] key_word_ff [4];
   logic [63:0] iv_high_ff, iv_low_ff;
   block_type   chain_ff, chain_in;
   block_type   blk_ff, blk_in;
   logic [3:0]  rnd_ff, rnd_in;
   logic [5:0]  idx_ff, idx_in;
   logic [2:0]  kmod_ff, kmod_in;
   logic [7:0]  rcon_ff, rcon_in;
   logic [31:0] win_ff [8];
   logic        rsp_valid_ff, rsp_valid_in;
   block_type   rsp_ff;

   // Round-key memory: four banks, one per column, one row per round.
   logic [31:0] rk_mem0 [15];
   logic [31:0] rk_mem1 [15];
   logic [31:0] rk_mem2 [15];
   logic [31:0] rk_mem3 [15];
   logic [31:0] rk_q [4];
   logic [3:0]  rd_row;

   logic        csr_write, key_write, req_fire, out_free, last_round, exp_done;
   logic [3:0]  nr;
   logic [2:0]  nk_last;
   logic [5:0]  exp_last;
   logic [31:0] w_back, w_key, w_temp, w_new;
   logic [63:0] key_sel;
   block_type   rk, round_out, final_out;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign key_write = csr_write & (csr_index <= REG_KEY_WORD3);

   // Key-size dependent counts; bit 1 selects the 256-bit key.
   always_comb begin
      priority if (key_size_ff[1]) begin
         nr = 4'd14; nk_last = 3'd7; exp_last = 6'd59; w_back = win_ff[7];
      end else if (key_size_ff[0]) begin
         nr = 4'd12; nk_last = 3'd5; exp_last = 6'd51; w_back = win_ff[5];
      end else begin
         nr = 4'd10; nk_last = 3'd3; exp_last = 6'd43; w_back = win_ff[3];
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= 2'd0;
         key_word_ff <= '{default: 64'd0};
         iv_high_ff <= IV_RESET;
         iv_low_ff <= IV_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_KEY_SIZE:  key_size_ff <= csr_data[1:0];
            REG_KEY_WORD0: key_word_ff[0] <= csr_data;
            REG_KEY_WORD1: key_word_ff[1] <= csr_data;
            REG_KEY_WORD2: key_word_ff[2] <= csr_data;
            REG_KEY_WORD3: key_word_ff[3] <= csr_data;
            REG_IV_HIGH:   iv_high_ff <= csr_data;
            REG_IV_LOW:    iv_low_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Key expansion: one word per cycle from a window of the last eight words.
   always_comb begin
      key_sel = key_word_ff[idx_ff[2:1]];
      w_key = idx_ff[0] ? key_sel[31:0] : key_sel[63:32];
      w_temp = win_ff[0];
      rcon_in = rcon_ff;
      if (kmod_ff == 3'd0) begin
         w_temp = sub_word({win_ff[0][23:0], win_ff[0][31:24]}) ^ {rcon_ff, 24'd0};
         if (idx_ff > {3'd0, nk_last}) begin
            rcon_in = xtime(rcon_ff);
         end
      end else if (key_size_ff[1] && kmod_ff == 3'd4) begin
         w_temp = sub_word(win_ff[0]);
      end
      w_new = (idx_ff <= {3'd0, nk_last}) ? w_key : (w_back ^ w_temp);
      kmod_in = (kmod_ff == nk_last) ? 3'd0 : kmod_ff + 3'd1;
      idx_in = idx_ff + 6'd1;
      exp_done = (idx_ff == exp_last);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EXPAND) begin
         win_ff[0] <= w_new;
         for (int k = 1; k < 8; k++) begin
            win_ff[k] <= win_ff[k - 1];
         end
      end
   end

   // Round-key memory write (expansion) and registered row read.
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXPAND) begin
         unique case (idx_ff[1:0])
            2'd0: rk_mem0[idx_ff[5:2]] <= w_new;
            2'd1: rk_mem1[idx_ff[5:2]] <= w_new;
            2'd2: rk_mem2[idx_ff[5:2]] <= w_new;
            default: rk_mem3[idx_ff[5:2]] <= w_new;
         endcase
      end
      rk_q[0] <= rk_mem0[rd_row];
      rk_q[1] <= rk_mem1[rd_row];
      rk_q[2] <= rk_mem2[rd_row];
      rk_q[3] <= rk_mem3[rd_row];
   end

   assign rk = {rk_q[0], rk_q[1], rk_q[2], rk_q[3]};

   // Round datapath.
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire = req_valid & req_ready;
   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign last_round = (state_ff == ST_RUN) && (rnd_ff == nr);
   assign round_out = mix_columns(sub_shift(blk_ff)) ^ rk;
   assign final_out = sub_shift(blk_ff) ^ rk;

   always_comb begin
      rd_row = (state_ff == ST_RUN && !last_round) ? rnd_ff + 4'd1 : rnd_ff;
      if (req_fire) begin
         rd_row = 4'd0;
      end
   end

   always_comb begin
      state_in = state_ff;
      blk_in = blk_ff;
      rnd_in = rnd_ff;
      chain_in = chain_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         ST_EXPAND: begin
            if (exp_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               blk_in = {req_plain_high, req_plain_low} ^
                        (req_restart_chain ? {iv_high_ff, iv_low_ff} : chain_ff);
               rnd_in = 4'd0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (rnd_ff == 4'd0) begin
               blk_in = blk_ff ^ rk;
               rnd_in = 4'd1;
            end else if (!last_round) begin
               blk_in = round_out;
               rnd_in = rnd_ff + 4'd1;
            end else if (out_free) begin
               chain_in = final_out;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (key_write) begin
         state_in = ST_EXPAND;
      end
   end

   // Control and data registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EXPAND;
         idx_ff <= 6'd0;
         kmod_ff <= 3'd0;
         rcon_ff <= RCON_FIRST;
         rnd_ff <= 4'd0;
         chain_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff <= rnd_in;
         chain_ff <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (key_write) begin
            idx_ff <= 6'd0;
            kmod_ff <= 3'd0;
            rcon_ff <= RCON_FIRST;
         end else if (state_ff == ST_EXPAND) begin
            idx_ff <= idx_in;
            kmod_ff <= kmod_in;
            rcon_ff <= rcon_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      if (last_round && out_free) begin
         rsp_ff <= final_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cipher_high = rsp_ff[127:64];
   assign rsp_cipher_low = rsp_ff[63:0];

`ifndef SYNTHESIS
   // No block starts while round keys are still being expanded.
   a_no_accept_expand: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> state_ff != ST_EXPAND) else $error("block accepted during expansion");

   // The round counter never passes the round count.
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> rnd_ff <= nr) else $error("round counter overran");

   // A new result always matches the stored chain value.
   a_chain_match: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> rsp_ff == chain_ff) else $error("chain value mismatch");

   // Expansion index stays inside the round-key memory.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXPAND |-> idx_ff <= exp_last) else $error("expansion index overran");
`endif

endmodule
